// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent checks on the block clock, masked while in reset.
`define BSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// The same check, but also active while in reset.
`define BSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`endif

// File: rtl/core/bsc_pkg.sv
`timescale 1ns / 1ps
package bsc_pkg;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [27:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               divide_error;
    } out_item_t;

    // Entry passed from front to back
    typedef struct packed {
        logic [31:0] tdiff;   // UT - AC6
        logic [18:0] up;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [1:0]  oss;
    } coef_t;

    typedef enum logic [2:0] {
        REG_AC123 = 3'd0,
        REG_AC456 = 3'd1,
        REG_B12   = 3'd2,
        REG_MCMD  = 3'd3,
        REG_OSS   = 3'd4
    } reg_idx_t;

    localparam int          CFG_DW    = 48;
    localparam logic [31:0] C_B6_OFS  = 32'd4000;
    localparam logic [31:0] C_ROUND   = 32'd32768;
    localparam logic [31:0] C_P_SCALE = 32'd50000;
    localparam logic [31:0] C_SIGN    = 32'h8000_0000;
    localparam logic [31:0] C_K1      = 32'd3038;
    localparam logic [31:0] C_K2      = 32'hFFFF_E343; // -7357
    localparam logic [31:0] C_K3      = 32'd3791;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// File: rtl/core/bsc_front.sv
`timescale 1ns / 1ps
module bsc_front import bsc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic [15:0] ac6,
    output logic     q_valid,
    input  logic     q_ready,
    output q_entry_t q_entry
);
    logic     valid_reg;
    q_entry_t entry_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (q_ready) begin
            valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            entry_reg.tdiff <= {16'd0, s_data.raw_temperature} - {16'd0, ac6};
            entry_reg.up    <= s_data.raw_pressure;
        end
    end
endmodule

// File: rtl/core/bsc_fifo.sv
`timescale 1ns / 1ps
module bsc_fifo import bsc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  q_entry_t in_entry,
    output logic     out_valid,
    input  logic     out_ready,
    output q_entry_t out_entry,
    output q_stat_t  stat
);
    q_entry_t   mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign in_ready   = !stat.full;
    assign out_valid  = !stat.empty;
    assign out_entry  = mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop) count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
        if (push) mem[wr_ptr_reg] <= in_entry;
    end
endmodule

// File: rtl/core/bsc_back.sv
`timescale 1ns / 1ps
module bsc_back import bsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  coef_t     coef,
    input  logic      q_valid,
    output logic      q_ready,
    input  q_entry_t  q_entry,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_T1, S_TDIV, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
        S_PDIV, S_P8, S_P9, S_P10, S_FIN
    } state_t;

    state_t      state_reg;
    logic [31:0] tdiff_reg, x1_reg, b5_reg, b6_reg, sq_reg, b3_reg, x3_reg;
    logic [31:0] b4_reg, b7_reg, p_reg;
    logic [18:0] up_reg;
    logic        err_reg, neg_reg, m_valid_reg;
    logic [31:0] quo_reg, rem_reg, dvsr_reg;
    logic [4:0]  cnt_reg;
    out_item_t   out_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b, prod;

    always_comb begin
        case (state_reg)
            S_T1:    begin mul_a = tdiff_reg;       mul_b = {16'd0, coef.ac5}; end
            S_P1:    begin mul_a = b6_reg;          mul_b = b6_reg;            end
            S_P2:    begin mul_a = sx16(coef.b2);   mul_b = sq_reg;            end
            S_P3:    begin mul_a = sx16(coef.ac2);  mul_b = b6_reg;            end
            S_P4:    begin mul_a = sx16(coef.ac3);  mul_b = b6_reg;            end
            S_P5:    begin mul_a = sx16(coef.b1);   mul_b = sq_reg;            end
            S_P6:    begin mul_a = {16'd0, coef.ac4}; mul_b = x3_reg + C_ROUND; end
            S_P7:    begin
                mul_a = {13'd0, up_reg} - b3_reg;
                mul_b = C_P_SCALE >> coef.oss;
            end
            S_P8:    begin
                mul_a = $unsigned($signed(p_reg) >>> 8);
                mul_b = $unsigned($signed(p_reg) >>> 8);
            end
            S_P9:    begin mul_a = x1_reg;          mul_b = C_K1;              end
            S_P10:   begin mul_a = C_K2;            mul_b = p_reg;             end
            default: begin mul_a = '0;              mul_b = '0;                end
        endcase
    end
    assign prod = mul_a * mul_b;

    // temperature step values
    logic [31:0] t_x1, t_den, t_num;
    assign t_x1  = $unsigned($signed(prod) >>> 15);
    assign t_den = t_x1 + sx16(coef.md);
    assign t_num = sx16(coef.mc) << 11;

    // B3 path
    logic [31:0] p3_x3, p3_t;
    assign p3_x3 = x1_reg + $unsigned($signed(prod) >>> 11);
    assign p3_t  = (((sx16(coef.ac1) << 2) + p3_x3) << coef.oss) + 32'd2;

    // restoring divider, one quotient bit a cycle
    logic [32:0] d_shift, d_diff;
    logic [31:0] d_quo, d_rem, d_q;
    assign d_shift = {rem_reg, quo_reg[31]};
    assign d_diff  = d_shift - {1'b0, dvsr_reg};
    assign d_quo   = {quo_reg[30:0], !d_diff[32]};
    assign d_rem   = d_diff[32] ? d_shift[31:0] : d_diff[31:0];
    assign d_q     = neg_reg ? (32'd0 - d_quo) : d_quo;

    logic [31:0] b5_t, t_out;
    assign b5_t  = x1_reg + d_q;
    assign t_out = $unsigned($signed(b5_reg + 32'd8) >>> 4);

    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_FIN) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        tdiff_reg <= q_entry.tdiff;
                        up_reg    <= q_entry.up;
                        err_reg   <= 1'b0;
                        state_reg <= S_T1;
                    end
                end
                S_T1: begin
                    x1_reg <= t_x1;
                    if (t_den == 32'd0) begin
                        err_reg   <= 1'b1;
                        b5_reg    <= t_x1;
                        b6_reg    <= t_x1 - C_B6_OFS;
                        state_reg <= S_P1;
                    end else begin
                        quo_reg   <= t_num[31] ? (32'd0 - t_num) : t_num;
                        dvsr_reg  <= t_den[31] ? (32'd0 - t_den) : t_den;
                        neg_reg   <= t_num[31] ^ t_den[31];
                        rem_reg   <= '0;
                        cnt_reg   <= 5'd31;
                        state_reg <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    quo_reg <= d_quo;
                    rem_reg <= d_rem;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        b5_reg    <= b5_t;
                        b6_reg    <= b5_t - C_B6_OFS;
                        state_reg <= S_P1;
                    end
                end
                S_P1: begin
                    sq_reg    <= $unsigned($signed(prod) >>> 12);
                    state_reg <= S_P2;
                end
                S_P2: begin
                    x1_reg    <= $unsigned($signed(prod) >>> 11);
                    state_reg <= S_P3;
                end
                S_P3: begin
                    // divide by 4 rounding toward zero
                    b3_reg    <= $unsigned($signed(p3_t[31] ? p3_t + 32'd3 : p3_t) >>> 2);
                    state_reg <= S_P4;
                end
                S_P4: begin
                    x1_reg    <= $unsigned($signed(prod) >>> 13);
                    state_reg <= S_P5;
                end
                S_P5: begin
                    x3_reg    <= $unsigned($signed(x1_reg + $unsigned($signed(prod) >>> 16)
                                 + 32'd2) >>> 2);
                    state_reg <= S_P6;
                end
                S_P6: begin
                    b4_reg    <= prod >> 15;
                    state_reg <= S_P7;
                end
                S_P7: begin
                    b7_reg <= prod;
                    if (b4_reg == 32'd0) begin
                        err_reg   <= 1'b1;
                        p_reg     <= '0;
                        state_reg <= S_P8;
                    end else begin
                        quo_reg   <= (prod < C_SIGN) ? (prod << 1) : prod;
                        dvsr_reg  <= b4_reg;
                        neg_reg   <= 1'b0;
                        rem_reg   <= '0;
                        cnt_reg   <= 5'd31;
                        state_reg <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    quo_reg <= d_quo;
                    rem_reg <= d_rem;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        p_reg     <= (b7_reg < C_SIGN) ? d_q : (d_q << 1);
                        state_reg <= S_P8;
                    end
                end
                S_P8: begin
                    x1_reg    <= prod;
                    state_reg <= S_P9;
                end
                S_P9: begin
                    x1_reg    <= $unsigned($signed(prod) >>> 16);
                    state_reg <= S_P10;
                end
                S_P10: begin
                    p_reg     <= p_reg + $unsigned($signed(x1_reg
                                 + $unsigned($signed(prod) >>> 16) + C_K3) >>> 4);
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        out_reg.temperature_tenths <= t_out[27:0];
                        out_reg.pressure_pa  <= $signed(p_reg);
                        out_reg.divide_error <= err_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/baro_sensor_compensation.sv
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// input    | s_valid / s_ready    | s_data (in_item_t): raw_temperature, raw_pressure
// result   | m_valid / m_ready    | m_data (out_item_t): temperature_tenths, pressure_pa,
//          |                      |   divide_error
// config   | cfg_valid / cfg_ready| cfg_index (register number), cfg_data
//
// The back end takes one item at a time, through the idle/load step, one temperature
// step, two 32-bit restoring divisions, ten steps on the shared 32x32 multiplier and
// the output step. A zero divisor skips its division. The front register and a two-entry
// queue take up to three further transactions while one is being worked on. Reset is
// synchronous, active low; it empties the queue and result register and clears all
// coefficients. A stalled result holds the back end in its final state; the front keeps
// accepting until the queue and the front register are full.
`include "assert_macros.svh"
module baro_sensor_compensation import bsc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);
    logic [47:0] ac123_reg, ac456_reg;
    logic [31:0] b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    coef_t       coef;

    // register writes are always taken; unknown indices are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac123_reg <= '0;
            ac456_reg <= '0;
            b12_reg   <= '0;
            mcmd_reg  <= '0;
            oss_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_AC123: ac123_reg <= cfg_data[47:0];
                REG_AC456: ac456_reg <= cfg_data[47:0];
                REG_B12:   b12_reg   <= cfg_data[31:0];
                REG_MCMD:  mcmd_reg  <= cfg_data[31:0];
                REG_OSS:   oss_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign coef.ac1 = ac123_reg[47:32];
    assign coef.ac2 = ac123_reg[31:16];
    assign coef.ac3 = ac123_reg[15:0];
    assign coef.ac4 = ac456_reg[47:32];
    assign coef.ac5 = ac456_reg[31:16];
    assign coef.ac6 = ac456_reg[15:0];
    assign coef.b1  = b12_reg[31:16];
    assign coef.b2  = b12_reg[15:0];
    assign coef.mc  = mcmd_reg[31:16];
    assign coef.md  = mcmd_reg[15:0];
    assign coef.oss = oss_reg;

    // front: input register, UT - AC6 formed on entry
    logic     fr_valid, fr_ready;
    q_entry_t fr_entry;
    bsc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .ac6     (coef.ac6),
        .q_valid (fr_valid),
        .q_ready (fr_ready),
        .q_entry (fr_entry)
    );

    // queue decouples front from back
    logic     bk_valid, bk_ready;
    q_entry_t bk_entry;
    q_stat_t  q_stat;
    bsc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_entry  (fr_entry),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_entry (bk_entry),
        .stat      (q_stat)
    );

    // back: multiply/divide sequencer and result register
    bsc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef    (coef),
        .q_valid (bk_valid),
        .q_ready (bk_ready),
        .q_entry (bk_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `BSC_ASSERT_ALWAYS(a_q_full_empty, !(q_stat.full && q_stat.empty), "queue full and empty")
    `BSC_ASSERT(a_front_stall, fr_valid && q_stat.full |-> !s_ready, "input taken on full queue")
    `BSC_ASSERT(a_cfg_ignore, cfg_valid && cfg_index > REG_OSS |=> $stable(oss_reg), "bad index")

endmodule
